// ----- hdl/xbs_pkg.sv -----
`default_nettype none
package xbs_pkg;

  localparam int unsigned BLOCK_BYTES = 128;
  localparam int unsigned ADDR_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned HDR_BYTES   = 3;

  // frame positions
  localparam logic [7:0] POS_SEQ      = 8'd1;
  localparam logic [7:0] POS_SEQ_INV  = 8'd2;
  localparam logic [7:0] POS_CHECK    = 8'(BLOCK_BYTES + HDR_BYTES);
  localparam logic [7:0] LEN_SUM      = 8'(BLOCK_BYTES + HDR_BYTES + 1);
  localparam logic [7:0] LEN_CRC      = 8'(BLOCK_BYTES + HDR_BYTES + 2);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_ETX = 8'h03;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  typedef enum logic [2:0] {
    OP_START = 3'd0,
    OP_LOAD  = 3'd1,
    OP_LINK  = 3'd2,
    OP_RX    = 3'd3,
    OP_TICK  = 3'd4,
    OP_END   = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_WAIT_REQ = 3'd1,
    PH_LOADING  = 3'd2,
    PH_SENDING  = 3'd3,
    PH_WAIT_ACK = 3'd4,
    PH_WAIT_EOT = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OPEN     = 3'd1,
    EV_ACKED    = 3'd2,
    EV_FAILED   = 3'd3,
    EV_ABORTED  = 3'd4,
    EV_COMPLETE = 3'd5
  } ev_t;

  typedef enum logic [1:0] {
    REG_REQ_RETRY = 2'd0,
    REG_ACK_RETRY = 2'd1,
    REG_NAK_LIMIT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] req_retry;
    logic [7:0] ack_retry;
    logic [7:0] nak_limit;
  } limits_t;

  typedef struct packed {
    logic       valid;
    logic       byte_valid;
    logic [7:0] tx_byte;
    ev_t        ev;
    logic       crc_used;
    logic [7:0] sequence_res;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } buf_req_t;

  // crc-16/xmodem, one byte msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/xbs_if.sv -----
`default_nettype none
interface xbs_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface xbs_out_if;
  logic       valid;
  logic       ready;
  logic       byte_valid;
  logic [7:0] tx_byte;
  logic [2:0] event_res;
  logic       crc_used;
  logic [7:0] sequence_res;

  modport source (output valid, output byte_valid, output tx_byte, output event_res,
                  output crc_used, output sequence_res, input ready);
  modport sink   (input valid, input byte_valid, input tx_byte, input event_res,
                  input crc_used, input sequence_res, output ready);
endinterface
`default_nettype wire

// ----- hdl/xmodem_block_sender_core.sv -----
`default_nettype none
// channel | dir | beat payload                                          | handshake
// in_ch   | in  | op, data_byte                                         | valid/ready
// out_ch  | out | byte_valid, tx_byte, event_res, crc_used, sequence_res | valid/ready
// cfg     | in  | cfg_index, cfg_wdata                                  | cfg_we only
//
// one item per cycle while the result is not stalled: an input register, then the
// session state machine and the block buffer (synchronous read, prefetched one position
// ahead) feed the result register that holds each result beat; items with no result vanish.
// rst_n is synchronous; the block buffer is not cleared, it is always filled before a read.
// a stalled result holds the machine; one more input beat is still taken while it waits.
module xmodem_block_sender_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  xbs_in_if.sink          in_ch,
  xbs_out_if.source       out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  logic              s1_valid_r;
  logic [2:0]        s1_op_r;
  logic [7:0]        s1_data_r;
  xbs_pkg::res_t     out_r;
  xbs_pkg::res_t     res;
  xbs_pkg::limits_t  lim_r;
  xbs_pkg::buf_req_t buf_req;
  logic [7:0]        rd_data;
  logic              advance;
  logic              proc;

  assign advance     = !out_r.valid || out_ch.ready;
  assign proc        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r   <= in_ch.op;
      s1_data_r <= in_ch.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else if (advance) begin
      out_r.valid <= proc && res.valid;
    end
    if (proc) begin
      out_r.byte_valid   <= res.byte_valid;
      out_r.tx_byte      <= res.tx_byte;
      out_r.ev           <= res.ev;
      out_r.crc_used     <= res.crc_used;
      out_r.sequence_res <= res.sequence_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.req_retry <= 8'd10;
      lim_r.ack_retry <= 8'd10;
      lim_r.nak_limit <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        xbs_pkg::REG_REQ_RETRY: lim_r.req_retry <= cfg_wdata;
        xbs_pkg::REG_ACK_RETRY: lim_r.ack_retry <= cfg_wdata;
        xbs_pkg::REG_NAK_LIMIT: lim_r.nak_limit <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  xbs_fsm u_fsm (
    .clk       (clk),
    .rst_n     (rst_n),
    .proc      (proc),
    .op        (s1_op_r),
    .data_byte (s1_data_r),
    .lim       (lim_r),
    .rd_data   (rd_data),
    .res       (res),
    .buf_req   (buf_req)
  );

  xbs_buf u_buf (
    .clk   (clk),
    .req   (buf_req),
    .rdata (rd_data)
  );

  assign out_ch.valid        = out_r.valid;
  assign out_ch.byte_valid   = out_r.byte_valid;
  assign out_ch.tx_byte      = out_r.tx_byte;
  assign out_ch.event_res    = out_r.ev;
  assign out_ch.crc_used     = out_r.crc_used;
  assign out_ch.sequence_res = out_r.sequence_res;

endmodule
`default_nettype wire

// ----- hdl/xbs_buf.sv -----
`default_nettype none
module xbs_buf (
  input  wire logic              clk,
  input  wire xbs_pkg::buf_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0] mem [xbs_pkg::BLOCK_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/xbs_fsm.sv -----
`default_nettype none
module xbs_fsm (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             proc,
  input  wire logic [2:0]       op,
  input  wire logic [7:0]       data_byte,
  input  wire xbs_pkg::limits_t lim,
  input  wire logic [7:0]       rd_data,
  output xbs_pkg::res_t         res,
  output xbs_pkg::buf_req_t     buf_req
);

  xbs_pkg::phase_t phase_r, phase_nxt;
  logic        crc_mode_r, crc_mode_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [7:0]  retry_r, retry_nxt;
  logic [7:0]  idx_r, idx_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic [8:0]  retry_inc;
  logic [15:0] crc_upd;
  logic [7:0]  idx_inc;
  logic [7:0]  frame_len;
  logic        is_op_rx;

  assign retry_inc = {1'b0, retry_r} + 9'd1;
  assign crc_upd   = xbs_pkg::crc16_byte(crc_r, data_byte);
  assign idx_inc   = idx_r + 8'd1;
  assign frame_len = crc_mode_r ? xbs_pkg::LEN_CRC : xbs_pkg::LEN_SUM;
  assign is_op_rx  = (op == xbs_pkg::OP_RX);

  // next state
  always_comb begin
    phase_nxt    = phase_r;
    crc_mode_nxt = crc_mode_r;
    seq_nxt      = seq_r;
    retry_nxt    = retry_r;
    idx_nxt      = idx_r;
    sum_nxt      = sum_r;
    crc_nxt      = crc_r;
    if (proc) begin
      if (op == xbs_pkg::OP_START) begin
        phase_nxt = xbs_pkg::PH_WAIT_REQ;
        seq_nxt   = 8'd1;
        retry_nxt = 8'd0;
        idx_nxt   = 8'd0;
        sum_nxt   = 8'd0;
        crc_nxt   = 16'd0;
      end else begin
        unique case (phase_r)
          xbs_pkg::PH_WAIT_REQ: begin
            if (is_op_rx && (data_byte == xbs_pkg::CH_NAK || data_byte == xbs_pkg::CH_C)) begin
              crc_mode_nxt = (data_byte == xbs_pkg::CH_C);
              retry_nxt    = 8'd0;
              idx_nxt      = 8'd0;
              sum_nxt      = 8'd0;
              crc_nxt      = 16'd0;
              phase_nxt    = xbs_pkg::PH_LOADING;
            end else if (is_op_rx &&
                         (data_byte == xbs_pkg::CH_CAN || data_byte == xbs_pkg::CH_ETX)) begin
              phase_nxt = xbs_pkg::PH_IDLE;
            end else if (is_op_rx || op == xbs_pkg::OP_TICK) begin
              if (retry_inc <= {1'b0, lim.req_retry}) begin
                retry_nxt = retry_inc[7:0];
              end else begin
                phase_nxt = xbs_pkg::PH_IDLE;
              end
            end
          end
          xbs_pkg::PH_LOADING: begin
            if (op == xbs_pkg::OP_LOAD) begin
              sum_nxt = sum_r + data_byte;
              crc_nxt = crc_upd;
              if (idx_inc >= 8'(xbs_pkg::BLOCK_BYTES)) begin
                idx_nxt   = 8'd0;
                phase_nxt = xbs_pkg::PH_SENDING;
              end else begin
                idx_nxt = idx_inc;
              end
            end else if (op == xbs_pkg::OP_END && idx_r == 8'd0) begin
              phase_nxt = xbs_pkg::PH_WAIT_EOT;
            end
          end
          xbs_pkg::PH_SENDING: begin
            if (op == xbs_pkg::OP_LINK) begin
              if (idx_inc >= frame_len) begin
                idx_nxt   = 8'd0;
                phase_nxt = xbs_pkg::PH_WAIT_ACK;
              end else begin
                idx_nxt = idx_inc;
              end
            end
          end
          xbs_pkg::PH_WAIT_ACK: begin
            if (is_op_rx && data_byte == xbs_pkg::CH_ACK) begin
              seq_nxt   = seq_r + 8'd1;
              retry_nxt = 8'd0;
              idx_nxt   = 8'd0;
              sum_nxt   = 8'd0;
              crc_nxt   = 16'd0;
              phase_nxt = xbs_pkg::PH_LOADING;
            end else if (is_op_rx && data_byte == xbs_pkg::CH_NAK) begin
              if (retry_inc < {1'b0, lim.nak_limit}) begin
                retry_nxt = retry_inc[7:0];
                idx_nxt   = 8'd0;
                phase_nxt = xbs_pkg::PH_SENDING;
              end else begin
                phase_nxt = xbs_pkg::PH_IDLE;
              end
            end else if (is_op_rx && data_byte == xbs_pkg::CH_CAN) begin
              phase_nxt = xbs_pkg::PH_IDLE;
            end else if (is_op_rx || op == xbs_pkg::OP_TICK) begin
              if (retry_inc <= {1'b0, lim.ack_retry}) begin
                retry_nxt = retry_inc[7:0];
              end else begin
                phase_nxt = xbs_pkg::PH_IDLE;
              end
            end
          end
          xbs_pkg::PH_WAIT_EOT: begin
            if (is_op_rx && data_byte == xbs_pkg::CH_ACK) begin
              phase_nxt = xbs_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // outputs
  always_comb begin
    res              = '0;
    res.ev           = xbs_pkg::EV_NONE;
    res.crc_used     = crc_mode_nxt;
    res.sequence_res = seq_nxt;
    buf_req.we       = 1'b0;
    buf_req.waddr    = idx_r[xbs_pkg::ADDR_W-1:0];
    buf_req.wdata    = data_byte;
    // prefetch the data byte for the next frame position
    buf_req.raddr    = idx_nxt[xbs_pkg::ADDR_W-1:0] -
                       xbs_pkg::ADDR_W'(xbs_pkg::HDR_BYTES);
    if (proc && op != xbs_pkg::OP_START) begin
      unique case (phase_r)
        xbs_pkg::PH_WAIT_REQ: begin
          if (is_op_rx && (data_byte == xbs_pkg::CH_NAK || data_byte == xbs_pkg::CH_C)) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_OPEN;
          end else if (is_op_rx &&
                       (data_byte == xbs_pkg::CH_CAN || data_byte == xbs_pkg::CH_ETX)) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_FAILED;
          end else if ((is_op_rx || op == xbs_pkg::OP_TICK) &&
                       retry_inc > {1'b0, lim.req_retry}) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_FAILED;
          end
        end
        xbs_pkg::PH_LOADING: begin
          if (op == xbs_pkg::OP_LOAD) begin
            buf_req.we = 1'b1;
          end else if (op == xbs_pkg::OP_END && idx_r == 8'd0) begin
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.tx_byte    = xbs_pkg::CH_EOT;
          end
        end
        xbs_pkg::PH_SENDING: begin
          if (op == xbs_pkg::OP_LINK) begin
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            if (idx_r == 8'd0) begin
              res.tx_byte = xbs_pkg::CH_SOH;
            end else if (idx_r == xbs_pkg::POS_SEQ) begin
              res.tx_byte = seq_r;
            end else if (idx_r == xbs_pkg::POS_SEQ_INV) begin
              res.tx_byte = ~seq_r;
            end else if (idx_r < xbs_pkg::POS_CHECK) begin
              res.tx_byte = rd_data;
            end else if (!crc_mode_r) begin
              res.tx_byte = sum_r;
            end else if (idx_r == xbs_pkg::POS_CHECK) begin
              res.tx_byte = crc_r[15:8];
            end else begin
              res.tx_byte = crc_r[7:0];
            end
          end
        end
        xbs_pkg::PH_WAIT_ACK: begin
          if (is_op_rx && data_byte == xbs_pkg::CH_ACK) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_ACKED;
          end else if (is_op_rx && data_byte == xbs_pkg::CH_NAK) begin
            if (retry_inc >= {1'b0, lim.nak_limit}) begin
              res.valid = 1'b1;
              res.ev    = xbs_pkg::EV_ABORTED;
            end
          end else if (is_op_rx && data_byte == xbs_pkg::CH_CAN) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_ABORTED;
          end else if ((is_op_rx || op == xbs_pkg::OP_TICK) &&
                       retry_inc > {1'b0, lim.ack_retry}) begin
            res.valid      = 1'b1;
            res.byte_valid = 1'b1;
            res.tx_byte    = xbs_pkg::CH_CAN;
            res.ev         = xbs_pkg::EV_ABORTED;
          end
        end
        xbs_pkg::PH_WAIT_EOT: begin
          if (is_op_rx && data_byte == xbs_pkg::CH_ACK) begin
            res.valid = 1'b1;
            res.ev    = xbs_pkg::EV_COMPLETE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= xbs_pkg::PH_IDLE;
      crc_mode_r <= 1'b0;
      seq_r      <= 8'd1;
      retry_r    <= 8'd0;
      idx_r      <= 8'd0;
      sum_r      <= 8'd0;
      crc_r      <= 16'd0;
    end else begin
      phase_r    <= phase_nxt;
      crc_mode_r <= crc_mode_nxt;
      seq_r      <= seq_nxt;
      retry_r    <= retry_nxt;
      idx_r      <= idx_nxt;
      sum_r      <= sum_nxt;
      crc_r      <= crc_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- dv/xbs_sender_checker.sv -----
module xbs_sender_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  xbs_in_if               in_ch,
  xbs_out_if              out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       drained,
  output int              pending,
  output int              fails
);
  import xbs_pkg::*;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] tx_byte;
    ev_t        ev;
    logic       crc_used;
    logic [7:0] seq;
  } link_beat_t;

  localparam int unsigned FIRST_CHECK = BLOCK_BYTES + 3;

  limits_t      lim;
  phase_t       session_phase;
  logic         crc_on;
  logic [7:0]   seq;
  int unsigned  retries;
  logic [7:0]   blk [BLOCK_BYTES];
  int unsigned  pos;
  logic [7:0]   sum;
  logic [15:0]  crc;
  logic         drained_seen;

  link_beat_t   expected_beats [$];

  // crc-16/xmodem, feedback taken bit by bit from the msb
  function automatic logic [15:0] crc_xmodem_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    int          i;
    c = acc;
    for (i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  function automatic void clear_block();
    pos = 0;
    sum = 8'h00;
    crc = 16'h0000;
  endfunction

  function automatic link_beat_t make_beat(input logic bv, input logic [7:0] tx, input ev_t ev);
    link_beat_t r;
    r.byte_valid = bv;
    r.tx_byte    = bv ? tx : 8'h00;
    r.ev         = ev;
    r.crc_used   = crc_on;
    r.seq        = seq;
    return r;
  endfunction

  // one input beat through the sender; returns 1 when it produces a result beat
  function automatic bit advance_session(input logic [2:0] op, input logic [7:0] b,
                                         output link_beat_t r);
    int unsigned bump;
    int unsigned frame_len;
    logic [7:0]  tx;
    bump      = retries + 1;
    frame_len = crc_on ? BLOCK_BYTES + 5 : BLOCK_BYTES + 4;
    r         = make_beat(1'b0, 8'h00, EV_NONE);
    if (op == OP_START) begin
      session_phase = PH_WAIT_REQ;
      seq = 8'd1;
      retries = 0;
      clear_block();
      return 1'b0;
    end
    case (session_phase)
      PH_WAIT_REQ: begin
        if (op == OP_RX && (b == CH_NAK || b == CH_C)) begin
          crc_on = (b == CH_C);
          retries = 0;
          clear_block();
          session_phase = PH_LOADING;
          r = make_beat(1'b0, 8'h00, EV_OPEN);
          return 1'b1;
        end
        if (op == OP_RX && (b == CH_CAN || b == CH_ETX)) begin
          session_phase = PH_IDLE;
          r = make_beat(1'b0, 8'h00, EV_FAILED);
          return 1'b1;
        end
        if (op == OP_RX || op == OP_TICK) begin
          if (bump <= lim.req_retry) begin
            retries = bump;
            return 1'b0;
          end
          session_phase = PH_IDLE;
          r = make_beat(1'b0, 8'h00, EV_FAILED);
          return 1'b1;
        end
      end
      PH_LOADING: begin
        if (op == OP_LOAD) begin
          blk[pos] = b;
          sum = sum + b;
          crc = crc_xmodem_step(crc, b);
          pos++;
          if (pos >= BLOCK_BYTES) begin
            pos = 0;
            session_phase = PH_SENDING;
          end
          return 1'b0;
        end
        if (op == OP_END && pos == 0) begin
          session_phase = PH_WAIT_EOT;
          r = make_beat(1'b1, CH_EOT, EV_NONE);
          return 1'b1;
        end
      end
      PH_SENDING: begin
        if (op == OP_LINK) begin
          if (pos == 0) tx = CH_SOH;
          else if (pos == 1) tx = seq;
          else if (pos == 2) tx = ~seq;
          else if (pos < FIRST_CHECK) tx = blk[pos - 3];
          else if (!crc_on) tx = sum;
          else if (pos == FIRST_CHECK) tx = crc[15:8];
          else tx = crc[7:0];
          r = make_beat(1'b1, tx, EV_NONE);
          pos++;
          if (pos >= frame_len) begin
            pos = 0;
            session_phase = PH_WAIT_ACK;
          end
          return 1'b1;
        end
      end
      PH_WAIT_ACK: begin
        if (op == OP_RX && b == CH_ACK) begin
          seq = seq + 8'd1;
          retries = 0;
          clear_block();
          session_phase = PH_LOADING;
          r = make_beat(1'b0, 8'h00, EV_ACKED);
          return 1'b1;
        end
        if (op == OP_RX && b == CH_NAK) begin
          if (bump < lim.nak_limit) begin
            retries = bump;
            pos = 0;
            session_phase = PH_SENDING;
            return 1'b0;
          end
          session_phase = PH_IDLE;
          r = make_beat(1'b0, 8'h00, EV_ABORTED);
          return 1'b1;
        end
        if (op == OP_RX && b == CH_CAN) begin
          session_phase = PH_IDLE;
          r = make_beat(1'b0, 8'h00, EV_ABORTED);
          return 1'b1;
        end
        if (op == OP_RX || op == OP_TICK) begin
          if (bump <= lim.ack_retry) begin
            retries = bump;
            return 1'b0;
          end
          session_phase = PH_IDLE;
          r = make_beat(1'b1, CH_CAN, EV_ABORTED);
          return 1'b1;
        end
      end
      PH_WAIT_EOT: begin
        if (op == OP_RX && b == CH_ACK) begin
          session_phase = PH_IDLE;
          r = make_beat(1'b0, 8'h00, EV_COMPLETE);
          return 1'b1;
        end
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  initial begin
    fails   = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    link_beat_t want;
    if (!rst_n) begin
      lim.req_retry <= 8'd10;
      lim.ack_retry <= 8'd10;
      lim.nak_limit <= 8'd10;
      session_phase = PH_IDLE;
      crc_on = 1'b0;
      seq = 8'd1;
      retries = 0;
      clear_block();
      drained_seen = 1'b0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_REQ_RETRY: lim.req_retry <= cfg_wdata;
          REG_ACK_RETRY: lim.ack_retry <= cfg_wdata;
          REG_NAK_LIMIT: lim.nak_limit <= cfg_wdata;
          default: ;
        endcase
      end
      // result side first so a beat never matches an item taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: tx_byte %02h event %0d", out_ch.tx_byte,
                 out_ch.event_res);
          fails++;
        end else begin
          want = expected_beats.pop_front();
          if (out_ch.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_ch.byte_valid);
            fails++;
          end
          if (out_ch.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_ch.tx_byte);
            fails++;
          end
          if (out_ch.event_res !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, out_ch.event_res);
            fails++;
          end
          if (out_ch.crc_used !== want.crc_used) begin
            $error("crc_used: expected %0b, got %0b", want.crc_used, out_ch.crc_used);
            fails++;
          end
          if (out_ch.sequence_res !== want.seq) begin
            $error("sequence_res: expected %0d, got %0d", want.seq, out_ch.sequence_res);
            fails++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (advance_session(in_ch.op, in_ch.data_byte, want)) expected_beats.push_back(want);
      end
      if (drained && !drained_seen) begin
        drained_seen = 1'b1;
        if (expected_beats.size() != 0) begin
          $error("%0d expected result beats never arrived", expected_beats.size());
          fails++;
        end
      end
    end
    pending <= expected_beats.size();
  end

endmodule

// ----- dv/tb_xmodem_block_sender_core.sv -----
module tb_xmodem_block_sender_core;
  import xbs_pkg::*;

  // op codes the block has no use for
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_wdata;
  logic       drained;
  logic       hold_req;
  int         pending;
  int         fails;

  int         lim_req = 10;
  int         lim_ack = 10;
  int         lim_nak = 10;
  int         retries;
  int         burst_left = 0;
  int         items_sent = 0;
  bit         crc_on;
  bit         hold_pending = 1'b0;

  xbs_in_if  in_ch ();
  xbs_out_if out_ch ();

  xmodem_block_sender_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  xbs_sender_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .drained   (drained),
    .pending   (pending),
    .fails     (fails)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // offer one beat and hold it until taken; called right after a rising edge
  task automatic send_item(input logic [2:0] op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic logic [7:0] stray_byte();
    logic [7:0] v;
    do v = 8'($urandom);
    while (v == CH_NAK || v == CH_C || v == CH_CAN || v == CH_ETX || v == CH_ACK);
    return v;
  endfunction

  task automatic send_retry_event();
    if ($urandom_range(0, 1)) send_item(OP_TICK, 8'($urandom));
    else send_item(OP_RX, stray_byte());
  endtask

  task automatic wait_quiet();
    int guard;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    // results-free items may still sit in the two-stage pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input int rq, input int ak, input int nk);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_index <= REG_REQ_RETRY;
    cfg_wdata <= 8'(rq);
    @(posedge clk);
    cfg_index <= REG_ACK_RETRY;
    cfg_wdata <= 8'(ak);
    @(posedge clk);
    cfg_index <= REG_NAK_LIMIT;
    cfg_wdata <= 8'(nk);
    @(posedge clk);
    cfg_we  <= 1'b0;
    lim_req = rq;
    lim_ack = ak;
    lim_nak = nk;
  endtask

  // load one block, push the frame out, then play the receiver's answer
  task automatic send_block(output bit ok);
    int          i;
    int          k;
    int          choice;
    int          pattern;
    int unsigned flen;
    logic [7:0]  b;
    pattern = $urandom_range(0, 7);
    for (i = 0; i < BLOCK_BYTES; i++) begin
      b = (pattern == 0) ? 8'h00 : (pattern == 1) ? 8'hFF : 8'($urandom);
      send_item(OP_LOAD, b);
      if (i < BLOCK_BYTES - 1 && $urandom_range(0, 40) == 0) begin
        case ($urandom_range(0, 3))
          0: send_item(OP_LINK, 8'($urandom));
          1: send_item(OP_RX, 8'($urandom));
          2: send_item(OP_TICK, 8'($urandom));
          default: send_item(OP_END, 8'($urandom));
        endcase
      end
    end
    retries = 0;
    flen = crc_on ? BLOCK_BYTES + 5 : BLOCK_BYTES + 4;
    forever begin
      if (hold_pending) begin
        hold_req <= 1'b1;
        hold_pending = 1'b0;
      end
      for (i = 0; i < flen; i++) begin
        if ($urandom_range(0, 30) == 0) begin
          case ($urandom_range(0, 3))
            0: send_item(OP_LOAD, 8'($urandom));
            1: send_item(OP_RX, 8'($urandom));
            2: send_item(OP_TICK, 8'($urandom));
            default: send_item(OP_END, 8'($urandom));
          endcase
        end
        send_item(OP_LINK, 8'($urandom));
      end
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_LOAD, 8'($urandom));
          1: send_item(OP_LINK, 8'($urandom));
          default: send_item(OP_END, 8'($urandom));
        endcase
      end
      k = $urandom_range(0, 2);
      repeat (k) begin
        if (retries + 1 <= lim_ack) begin
          retries++;
          send_retry_event();
        end
      end
      choice = $urandom_range(0, 19);
      if (choice == 0) begin
        send_item(OP_RX, CH_CAN);
        ok = 1'b0;
        return;
      end
      if (choice == 1) begin
        // run the ack-wait retries out: CAN goes on the link
        repeat (lim_ack - retries + 1) send_retry_event();
        ok = 1'b0;
        return;
      end
      if (choice <= 5) begin
        send_item(OP_RX, CH_NAK);
        if (retries + 1 >= lim_nak) begin
          ok = 1'b0;
          return;
        end
        retries++;
      end else begin
        send_item(OP_RX, CH_ACK);
        ok = 1'b1;
        return;
      end
    end
  endtask

  task automatic run_session();
    int fate;
    int k;
    int n;
    int blocks;
    bit ok;
    if ($urandom_range(0, 3) == 0)
      send_item($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, 8'($urandom));
    send_item(OP_START, 8'($urandom));
    fate = $urandom_range(0, 15);
    if (fate == 0) begin
      repeat (lim_req + 1) send_retry_event();
      return;
    end
    if (fate == 1) begin
      repeat ($urandom_range(0, (lim_req < 2) ? lim_req : 2)) send_retry_event();
      send_item(OP_RX, $urandom_range(0, 1) ? CH_CAN : CH_ETX);
      return;
    end
    k = (fate == 2) ? lim_req : $urandom_range(0, (lim_req < 3) ? lim_req : 3);
    repeat (k) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 2))
          0: send_item(OP_LOAD, 8'($urandom));
          1: send_item(OP_LINK, 8'($urandom));
          default: send_item(OP_END, 8'($urandom));
        endcase
      end
      send_retry_event();
    end
    crc_on = $urandom_range(0, 1);
    send_item(OP_RX, crc_on ? CH_C : CH_NAK);
    blocks = ($urandom_range(0, 5) == 0) ? 2 : $urandom_range(0, 1);
    for (n = 0; n < blocks; n++) begin
      send_block(ok);
      if (!ok) return;
      // a fresh start mid-session restarts it
      if ($urandom_range(0, 30) == 0) return;
    end
    send_item(OP_END, 8'($urandom));
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 4))
        0: send_item(OP_TICK, 8'($urandom));
        1: send_item(OP_RX, stray_byte());
        2: send_item(OP_RX, CH_NAK);
        3: send_item(OP_LINK, 8'($urandom));
        default: send_item(OP_END, 8'($urandom));
      endcase
    end
    send_item(OP_RX, CH_ACK);
  endtask

  // receiver: stall patterns in segments, plus one long hold-off on request
  initial begin : receiver
    int  seg;
    int  mode;
    int  cnt;
    bit  hold_done;
    out_ch.ready <= 1'b0;
    cnt = 0;
    hold_done = 1'b0;
    forever begin
      seg  = $urandom_range(10, 150);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req && !hold_done) begin
          hold_done = 1'b1;
          out_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (cnt % 4) != 3;
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
        cnt++;
      end
    end
  end

  initial begin : stimulus
    int p;
    int mark;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_START;
    in_ch.data_byte <= 8'h00;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_REQ_RETRY;
    cfg_wdata       <= 8'h00;
    drained         <= 1'b0;
    hold_req        <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing open: spare ops, end and link are dropped
    send_item(OP_SPARE_6, 8'hFF);
    send_item(OP_SPARE_7, 8'h00);
    send_item(OP_END, 8'h00);
    send_item(OP_LINK, 8'hFF);
    // request wait: retries then cancel, then etx
    send_item(OP_START, 8'hAA);
    send_item(OP_RX, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_RX, CH_CAN);
    send_item(OP_START, 8'h55);
    send_item(OP_RX, CH_ETX);
    // empty crc session: eot, noise, nak ignored, ack completes
    send_item(OP_START, 8'h00);
    send_item(OP_RX, CH_C);
    send_item(OP_END, 8'h00);
    send_item(OP_RX, 8'h00);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_RX, CH_NAK);
    send_item(OP_RX, CH_ACK);
    // partial block: end ignored, start restarts while loading and while in eot wait
    send_item(OP_START, 8'h00);
    send_item(OP_RX, CH_NAK);
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_END, 8'h00);
    send_item(OP_START, 8'hFF);
    send_item(OP_RX, CH_C);
    send_item(OP_END, 8'hFF);
    send_item(OP_START, 8'h00);
    wait_quiet();

    for (p = 0; p < 6; p++) begin
      case (p)
        1: set_limits(0, 0, 1);
        2: set_limits(255, 255, 255);
        3: set_limits(1, 1, 2);
        4: set_limits($urandom_range(0, 12), $urandom_range(0, 12), $urandom_range(1, 12));
        5: set_limits($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 255));
        default: ;
      endcase
      if (p == 2) hold_pending = 1'b1;
      mark = items_sent;
      while (items_sent < mark + PHASE_ITEMS) run_session();
    end

    wait_quiet();
    drained <= 1'b1;
    repeat (3) @(posedge clk);
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- xmodem_block_sender_core.f -----
hdl/xbs_pkg.sv
hdl/xbs_if.sv
hdl/xbs_buf.sv
hdl/xbs_fsm.sv
hdl/xmodem_block_sender_core.sv
dv/xbs_sender_checker.sv
dv/tb_xmodem_block_sender_core.sv
